### hw/rtl/ffha_pkg.sv
// shared types and codes for the first-fit heap allocator
// no dependencies
`default_nettype none
package ffha_pkg;

  localparam int OFF_W  = 16;
  localparam int SIZE_W = 17;
  localparam int CNT_W  = 7;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              used;
  } entry_t;

endpackage
`default_nettype wire

### hw/rtl/ffha_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hw/rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator. One request at a time: after reset the S_INIT state writes the
// initial block. A request walks the block table in ram, reading and checking one entry
// at a time, then a split or merge shifts the entries above the hit one entry at a time,
// and the core is ready again only after that, plus any wait for the previous result to
// be taken. The single ram port pair is why entries are walked and shifted one by one.
// depends on ffha_pkg and ffha_ram
`default_nettype none
module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 16,
  parameter int MIN_PAYLOAD  = 16,
  parameter int MAX_BLOCKS   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // req_size[16:0], free_address[32:17], zero pad
  input  wire logic [0:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata    // status, address, used_bytes, free_bytes, block_count
);

  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] SPLIT_MIN = SIZE_W'(HEADER_BYTES + MIN_PAYLOAD);
  localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_NX_RD, S_NX_CHK, S_MERGE,
    S_UP_RD, S_UP_WR, S_WR_NEW, S_WR_CUR, S_DN_RD, S_DN_WR, S_DONE
  } state_t;

  state_t            state;
  func_t             func_r;
  logic [17:0]       need;
  logic [OFF_W-1:0]  faddr;
  logic [IW-1:0]     idx;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  n;
  logic [1:0]        k;
  logic [OFF_W-1:0]  cur_off;
  logic [SIZE_W-1:0] cur_size;
  logic [SIZE_W-1:0] rest;
  logic [OFF_W-1:0]  prev_off;
  logic [SIZE_W-1:0] prev_size;
  logic              prev_used;
  logic              nx_free;
  logic [SIZE_W-1:0] nx_size;
  logic [SIZE_W-1:0] used_b;
  logic [SIZE_W-1:0] free_b;
  status_t           status_r;
  logic [OFF_W-1:0]  addr_r;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;

  logic [CNT_W-1:0]  idx_x;
  logic              hit_alloc;
  logic              hit_free;
  logic [SIZE_W-1:0] rest_c;
  logic              pf;
  logic [SIZE_W-1:0] merged;
  logic [17:0]       need_in;

  ffha_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready = (state == S_IDLE);
  assign idx_x    = CNT_W'(idx);
  assign need_in  = (18'(s_tdata[16:0]) + 18'd15) & ~18'd15;
  assign hit_alloc = !rd_data.used && ({1'b0, rd_data.size} >= need);
  assign hit_free  = rd_data.used && ((SIZE_W'(rd_data.offset) + HDR) == SIZE_W'(faddr));
  assign rest_c    = rd_data.size - need[SIZE_W-1:0];
  assign pf        = (idx != '0) && !prev_used;
  assign merged    = cur_size + (nx_free ? HDR + nx_size : '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = '{offset: cur_off, size: cur_size, used: 1'b1};
    rd_addr = idx;
    unique case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '{offset: '0, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES), used: 1'b0};
      end
      S_NX_RD: rd_addr = idx + IW'(1);
      S_UP_RD, S_DN_RD: rd_addr = j[IW-1:0];
      S_UP_WR: begin
        wr_en   = 1'b1;
        wr_addr = IW'(j + CNT_W'(1));
        wr_data = rd_data;
      end
      S_WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = idx + IW'(1);
        wr_data = '{offset: OFF_W'(18'(cur_off) + 18'(HDR) + need),
                    size: rest - HDR, used: 1'b0};
      end
      S_WR_CUR: wr_en = 1'b1;
      S_MERGE: begin
        wr_en = 1'b1;
        if (pf) begin
          wr_addr = idx - IW'(1);
          wr_data = '{offset: prev_off, size: prev_size + HDR + merged, used: 1'b0};
        end else begin
          wr_data = '{offset: cur_off, size: merged, used: 1'b0};
        end
      end
      S_DN_WR: begin
        wr_en   = 1'b1;
        wr_addr = IW'(j - CNT_W'(k));
        wr_data = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      n        <= CNT_W'(1);
      used_b   <= '0;
      free_b   <= SIZE_W'(HEAP_BYTES - HEADER_BYTES);
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (s_tvalid) begin
            func_r    <= func_t'(s_tuser[0]);
            need      <= need_in;
            faddr     <= s_tdata[32:17];
            idx       <= '0;
            prev_used <= 1'b1;
            addr_r    <= '0;
            if (func_t'(s_tuser[0]) == FN_ALLOC && s_tdata[16:0] == '0) begin
              status_r <= ST_NO_FIT;
              state    <= S_DONE;
            end else begin
              status_r <= ST_OK;
              state    <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          cur_off <= rd_data.offset;
          if (func_r == FN_ALLOC && hit_alloc) begin
            rest   <= rest_c;
            addr_r <= OFF_W'(SIZE_W'(rd_data.offset) + HDR);
            if (rest_c > SPLIT_MIN && n < MAXN) begin
              cur_size <= need[SIZE_W-1:0];
              used_b   <= used_b + need[SIZE_W-1:0];
              free_b   <= free_b - need[SIZE_W-1:0] - HDR;
              j        <= n - CNT_W'(1);
              state    <= S_UP_RD;
            end else begin
              cur_size <= rd_data.size;
              used_b   <= used_b + rd_data.size;
              free_b   <= free_b - rd_data.size;
              state    <= S_WR_CUR;
            end
          end else if (func_r == FN_FREE && hit_free) begin
            cur_size <= rd_data.size;
            nx_free  <= 1'b0;
            nx_size  <= '0;
            state    <= (idx_x + CNT_W'(1) < n) ? S_NX_RD : S_MERGE;
          end else begin
            prev_off  <= rd_data.offset;
            prev_size <= rd_data.size;
            prev_used <= rd_data.used;
            idx       <= idx + IW'(1);
            if (idx_x + CNT_W'(1) >= n) begin
              status_r <= (func_r == FN_ALLOC) ? ST_NO_FIT : ST_BAD_FREE;
              state    <= S_DONE;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_NX_RD: state <= S_NX_CHK;
        S_NX_CHK: begin
          nx_free <= !rd_data.used;
          nx_size <= rd_data.size;
          state   <= S_MERGE;
        end
        S_MERGE: begin
          used_b <= used_b - cur_size;
          free_b <= free_b + cur_size + (nx_free ? HDR : '0) + (pf ? HDR : '0);
          k      <= 2'(nx_free) + 2'(pf);
          j      <= idx_x + CNT_W'(1) + CNT_W'(nx_free);
          state  <= S_DN_RD;
        end
        S_UP_RD: begin
          if (j == idx_x) begin
            state <= S_WR_NEW;
          end else begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          j     <= j - CNT_W'(1);
          state <= S_UP_RD;
        end
        S_WR_NEW: begin
          n     <= n + CNT_W'(1);
          state <= S_WR_CUR;
        end
        S_WR_CUR: state <= S_DONE;
        S_DN_RD: begin
          if (j >= n || k == '0) begin
            n     <= n - CNT_W'(k);
            state <= S_DONE;
          end else begin
            state <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          j     <= j + CNT_W'(1);
          state <= S_DN_RD;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, n, free_b, used_b, addr_r, status_r};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (n >= CNT_W'(1)) && (n <= MAXN))
    else $error("block count out of range");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (24'(used_b) + 24'(free_b) + 24'(n) * 24'(HEADER_BYTES)
                           == 24'(HEAP_BYTES)))
    else $error("heap totals do not tile the heap");

  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !wr_en)
    else $error("table written while idle");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("result lost");

endmodule
`default_nettype wire

### sim/tb.sv
// regression bench for first_fit_heap_allocator_core: queued allocate/free requests,
// an in-bench block table predicts each result, random source idling and sink stalls
// depends on ffha_pkg and first_fit_heap_allocator_core
`timescale 1ns / 1ps
module tb;
  import ffha_pkg::*;

  localparam int HEAP = 65536;
  localparam int HDR = 16;
  localparam int MINP = 16;
  localparam int MAXB = 64;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    func_t             fn;
    logic [SIZE_W-1:0] req;
    logic [OFF_W-1:0]  addr;
  } request_t;

  // lowest field last, matching the result bus layout
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [SIZE_W-1:0] freeb;
    logic [SIZE_W-1:0] used;
    logic [OFF_W-1:0]  addr;
    status_t           st;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int errors = 0;
  int watchdog = 0;
  logic stim_done = 1'b0;
  logic s_tready_q = 1'b0;
  int check_idx = 0;
  logic finishing = 1'b0;

  int unsigned tbl_off[MAXB];
  int unsigned tbl_size[MAXB];
  bit tbl_used[MAXB];
  int unsigned tbl_n;
  int unsigned live_addrs[$];

  task automatic table_reset();
    tbl_off[0] = 0;
    tbl_size[0] = HEAP - HDR;
    tbl_used[0] = 1'b0;
    tbl_n = 1;
  endtask

  function automatic void drop_at(int unsigned idx);
    for (int unsigned i = idx; i + 1 < tbl_n; i++) begin
      tbl_off[i] = tbl_off[i+1];
      tbl_size[i] = tbl_size[i+1];
      tbl_used[i] = tbl_used[i+1];
    end
    tbl_n--;
  endfunction

  function automatic outcome_t predict_heap(request_t r);
    outcome_t o;
    int unsigned need, rest, i, used, fr;
    bit hit;
    o = '0;
    o.st = ST_OK;
    hit = 1'b0;
    if (r.fn == FN_ALLOC) begin
      o.st = ST_NO_FIT;
      if (r.req != 0) begin
        need = (int'(r.req) + 15) & ~15;
        for (i = 0; i < tbl_n && !hit; i++) begin
          if (!tbl_used[i] && tbl_size[i] >= need) begin
            hit = 1'b1;
            rest = tbl_size[i] - need;
            if (rest > HDR + MINP && tbl_n < MAXB) begin
              for (int unsigned k = tbl_n; k > i + 1; k--) begin
                tbl_off[k] = tbl_off[k-1];
                tbl_size[k] = tbl_size[k-1];
                tbl_used[k] = tbl_used[k-1];
              end
              tbl_n++;
              tbl_off[i+1] = (tbl_off[i] + HDR + need) & 16'hffff;
              tbl_size[i+1] = rest - HDR;
              tbl_used[i+1] = 1'b0;
              tbl_size[i] = need;
            end
            tbl_used[i] = 1'b1;
            o.st = ST_OK;
            o.addr = OFF_W'((tbl_off[i] + HDR) & 16'hffff);
          end
        end
      end
    end else begin
      for (i = 0; i < tbl_n && !hit; i++)
        if (tbl_used[i] && tbl_off[i] + HDR == r.addr) hit = 1'b1;
      if (!hit) begin
        o.st = ST_BAD_FREE;
      end else begin
        i--;
        tbl_used[i] = 1'b0;
        if (i + 1 < tbl_n && !tbl_used[i+1]) begin
          tbl_size[i] += HDR + tbl_size[i+1];
          drop_at(i + 1);
        end
        if (i > 0 && !tbl_used[i-1]) begin
          tbl_size[i-1] += HDR + tbl_size[i];
          drop_at(i);
        end
      end
    end
    used = 0;
    fr = 0;
    for (i = 0; i < tbl_n; i++)
      if (tbl_used[i]) used += tbl_size[i];
      else fr += tbl_size[i];
    o.used = used[SIZE_W-1:0];
    o.freeb = fr[SIZE_W-1:0];
    o.cnt = tbl_n[CNT_W-1:0];
    return o;
  endfunction

  // live addresses tracked at generation time by a shadow run of the predictor
  task automatic push_req(func_t fn, int unsigned req, int unsigned addr);
    request_t r;
    outcome_t o;
    r.fn = fn;
    r.req = req[SIZE_W-1:0];
    r.addr = addr[OFF_W-1:0];
    o = predict_heap(r);
    if (fn == FN_ALLOC && o.st == ST_OK) live_addrs.push_back(o.addr);
    if (fn == FN_FREE && o.st == ST_OK)
      foreach (live_addrs[k])
        if (live_addrs[k] == addr) begin
          live_addrs.delete(k);
          break;
        end
    pending_reqs.push_back(r);
    expected_outcomes.push_back(o);
  endtask

  function automatic int unsigned rand_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(1, 600);
    if (p < 85) return $urandom_range(1, 4096);
    if (p < 95) return $urandom_range(0, 131071);
    return $urandom_range(0, 32);
  endfunction

  task automatic random_phase(int n);
    int unsigned p, k;
    for (int j = 0; j < n; j++) begin
      p = $urandom_range(99);
      if (p < 50) begin
        push_req(FN_ALLOC, rand_size(), $urandom_range(65535));
      end else if (p < 88 && live_addrs.size() > 0) begin
        k = $urandom_range(live_addrs.size() - 1);
        push_req(FN_FREE, $urandom_range(131071), live_addrs[k]);
      end else if (p < 94 && live_addrs.size() > 0) begin
        k = $urandom_range(live_addrs.size() - 1);
        push_req(FN_FREE, 0, (live_addrs[k] + $urandom_range(1, 40)) & 16'hffff);
      end else begin
        push_req(FN_FREE, $urandom_range(131071), $urandom_range(65535));
      end
    end
  endtask

  // reference copy drives generation; reset it before the monitor's predictions are queued
  initial begin
    table_reset();
    push_req(FN_ALLOC, 0, 0);
    push_req(FN_ALLOC, 131071, 16'hffff);
    push_req(FN_ALLOC, 65536, 0);
    push_req(FN_ALLOC, 65520, 0);
    push_req(FN_FREE, 0, 16);
    push_req(FN_FREE, 0, 0);
    push_req(FN_ALLOC, 1, 0);
    push_req(FN_ALLOC, 16, 0);
    push_req(FN_ALLOC, 17, 0);
    push_req(FN_ALLOC, 65471, 0);
    push_req(FN_FREE, 0, 20);
    push_req(FN_FREE, 0, 48);
    push_req(FN_FREE, 0, 48);
    push_req(FN_FREE, 0, 16);
    push_req(FN_FREE, 0, 80);
    push_req(FN_ALLOC, 65504, 0);
    push_req(FN_FREE, 0, 16);
    for (int j = 0; j < 66; j++) push_req(FN_ALLOC, 16, 0);
    push_req(FN_ALLOC, 1, 0);
    while (live_addrs.size() > 0) push_req(FN_FREE, 0, live_addrs.pop_front());
    random_phase(260);
    wait (pending_reqs.size() == 0);
    src_idle_pct = 47;
    random_phase(260);
    wait (pending_reqs.size() == 0);
    src_idle_pct = 0;
    snk_stall_pct = 47;
    random_phase(260);
    wait (pending_reqs.size() == 0);
    src_idle_pct = 27;
    snk_stall_pct = 27;
    random_phase(130);
    wait (pending_reqs.size() == 0);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    random_phase(40);
    wait (pending_reqs.size() == 0);
    stim_done = 1'b1;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // source: hold the request until taken, then pull the next
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready_q) begin
        void'(pending_reqs.pop_front());
      end
      if ((!s_tvalid || s_tready_q) && pending_reqs.size() > 0) begin
        if ($urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= {7'd0, pending_reqs[0].addr, pending_reqs[0].req};
          s_tuser <= pending_reqs[0].fn;
        end else begin
          s_tvalid <= 1'b0;
        end
      end else if (s_tvalid && s_tready_q) begin
        s_tvalid <= 1'b0;
      end
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want, got;
    if (rst) begin
      s_tready_q <= 1'b0;
    end else begin
      s_tready_q <= s_tvalid && s_tready;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (m_tvalid && m_tready) begin
        got = m_tdata[58:0];
        if (check_idx >= expected_outcomes.size()) begin
          $display("%0t unexpected result actual %h", $realtime, got);
          errors++;
        end else begin
          want = expected_outcomes[check_idx];
          if (got.st !== want.st || got.addr !== want.addr || got.used !== want.used
              || got.freeb !== want.freeb || got.cnt !== want.cnt) begin
            $display("%0t mismatch expected %h actual %h", $realtime, want, got);
            errors++;
          end
        end
        check_idx <= check_idx + 1;
      end
      if (watchdog >= WD_LIMIT) begin
        $display("first_fit_heap_allocator_core regression: fail");
        $finish;
      end
      if (stim_done && check_idx == expected_outcomes.size() && !finishing) finishing <= 1'b1;
    end
  end

  initial begin
    wait (finishing);
    repeat (200) @(posedge clk);
    if (errors == 0 && check_idx == expected_outcomes.size())
      $display("first_fit_heap_allocator_core regression: pass");
    else
      $display("first_fit_heap_allocator_core regression: fail");
    $finish;
  end

endmodule
